@@ rtl/core/lgs_pkg.sv @@
// Shared types, constants and the B3/S23 rule for the life generation stencil.
// Used by every module of the block; depends on nothing.
package lgs_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = 16;
  localparam int CFG_COLS_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_W       = 8;
  localparam int OUT_W      = 32;
  localparam int OUT_USED_W = 1 + ROW_W + COL_W;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

  // Result slots of one item, in release order.
  localparam logic [1:0] SLOT_UPPER_LEFT = 2'd0;
  localparam logic [1:0] SLOT_UPPER_END  = 2'd1;
  localparam logic [1:0] SLOT_CUR_LEFT   = 2'd2;
  localparam logic [1:0] SLOT_CUR_END    = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_row;
    logic             row_end;
    logic             alive;
  } lgs_item_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic             up;
    logic             mid;
  } lgs_wr_t;

  typedef struct packed {
    logic [3:0]       mask;
    logic [3:0]       alive;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } lgs_res_t;

  // Bits 0..8 hold three columns of three cells; bit 4 is the center.
  function automatic logic life_rule(logic [8:0] win);
    logic [3:0] sum;
    sum = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        sum = sum + {3'd0, win[i]};
      end
    end
    return (sum == 4'd3) || (win[4] && (sum == 4'd2));
  endfunction

endpackage

@@ rtl/core/lgs_line_buf.sv @@
// Two row stores (upper and middle row) with registered read and write bypass.
// Cleared by a sweep after reset. Depends on lgs_pkg.
module lgs_line_buf
  import lgs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  lgs_wr_t          wr,
  output logic             busy,
  output logic             up,
  output logic             mid
);

  logic             upper_mem  [MAX_COLS];
  logic             middle_mem [MAX_COLS];
  logic [COL_W:0]   clr_cnt;
  logic             bypass;

  assign busy   = (clr_cnt != MAX_COLS[COL_W:0]);
  assign bypass = wr.en && (wr.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      upper_mem[clr_cnt[COL_W-1:0]]  <= 1'b0;
      middle_mem[clr_cnt[COL_W-1:0]] <= 1'b0;
    end else if (wr.en) begin
      upper_mem[wr.addr]  <= wr.up;
      middle_mem[wr.addr] <= wr.mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up  <= bypass ? wr.up  : upper_mem[rd_addr];
      mid <= bypass ? wr.mid : middle_mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/lgs_window.sv @@
// Item stage: 3x3 window shift, B3/S23 evaluation of up to four cells and row store write-back.
// Depends on lgs_pkg.
module lgs_window
  import lgs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  lgs_item_t item_in,
  input  logic      up,
  input  logic      mid,
  input  logic      res_free,
  output logic      busy_stage,
  output lgs_wr_t   wr,
  output logic      res_load,
  output lgs_res_t  res
);

  logic      valid;
  lgs_item_t item;
  logic      fire;
  logic [8:0] window;
  logic [8:0] window_next;
  logic       up_e;
  logic       mid_e;
  logic [2:0] newcol;
  logic [2:0] ca;
  logic [2:0] cb;
  logic [2:0] cc;
  logic       upper_ok;
  logic       left_ok;

  assign fire       = valid && res_free;
  assign busy_stage = valid && !res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (fire) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (fire) begin
      window <= window_next;
    end
  end

  always_comb begin
    upper_ok    = (item.row != '0);
    left_ok     = (item.col != '0);
    up_e        = upper_ok && up;
    mid_e       = upper_ok && mid;
    newcol      = {item.alive, mid_e, up_e};
    window_next = left_ok ? {newcol, window[8:3]} : {newcol, 6'd0};
    ca          = window_next[2:0];
    cb          = window_next[5:3];
    cc          = window_next[8:6];

    res.mask[SLOT_UPPER_LEFT] = upper_ok && left_ok;
    res.mask[SLOT_UPPER_END]  = upper_ok && item.row_end;
    res.mask[SLOT_CUR_LEFT]   = item.last_row && left_ok;
    res.mask[SLOT_CUR_END]    = item.last_row && item.row_end;

    res.alive[SLOT_UPPER_LEFT] = life_rule(window_next);
    res.alive[SLOT_UPPER_END]  = life_rule({3'd0, cc, cb});
    res.alive[SLOT_CUR_LEFT]   = life_rule({1'b0, cc[2:1], 1'b0, cb[2:1], 1'b0, ca[2:1]});
    res.alive[SLOT_CUR_END]    = life_rule({3'd0, 1'b0, cc[2:1], 1'b0, cb[2:1]});
    res.row = item.row;
    res.col = item.col;

    wr.en   = fire;
    wr.addr = item.col;
    wr.up   = mid_e;
    wr.mid  = item.alive;
  end

  assign res_load = fire;

endmodule

@@ rtl/core/lgs_result_reg.sv @@
// Result register: holds the cells released by one item and sends them one beat at a time.
// Depends on lgs_pkg.
module lgs_result_reg
  import lgs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  lgs_res_t         res_in,
  input  logic             tready,
  output logic             tvalid,
  output logic [OUT_W-1:0] tdata,
  output logic             tlast,
  output logic             res_free
);

  logic [3:0]       mask;
  logic [3:0]       alive;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [3:0]       mask_drop;
  logic             beat;
  logic [1:0]       slot;
  logic [ROW_W-1:0] row_out;
  logic [COL_W-1:0] col_out;

  assign tvalid    = (mask != 4'd0);
  assign beat      = tvalid && tready;
  assign mask_drop = mask & (mask - 4'd1);
  assign res_free  = !tvalid || (beat && (mask_drop == 4'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= res_in.mask;
    end else if (beat) begin
      mask <= mask_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      alive <= res_in.alive;
      row   <= res_in.row;
      col   <= res_in.col;
    end
  end

  always_comb begin
    if (mask[SLOT_UPPER_LEFT]) begin
      slot = SLOT_UPPER_LEFT;
    end else if (mask[SLOT_UPPER_END]) begin
      slot = SLOT_UPPER_END;
    end else if (mask[SLOT_CUR_LEFT]) begin
      slot = SLOT_CUR_LEFT;
    end else begin
      slot = SLOT_CUR_END;
    end
    row_out = (slot == SLOT_UPPER_LEFT || slot == SLOT_UPPER_END) ? row - 1'b1 : row;
    col_out = (slot == SLOT_UPPER_LEFT || slot == SLOT_CUR_LEFT) ? col - 1'b1 : col;
    tdata   = {{(OUT_W - OUT_USED_W){1'b0}}, col_out, row_out, alive[slot]};
    tlast   = tvalid && (slot == SLOT_CUR_END);
  end

endmodule

@@ rtl/core/life_generation_stencil.sv @@
// Top level of the Game of Life B3/S23 next-generation stencil.
// Holds the configuration registers and the raster position; instantiates
// lgs_line_buf, lgs_window and lgs_result_reg. Depends on lgs_pkg.
//
// Cells of one generation enter on the s_axis channel, one per beat, in raster
// order over grid_rows x grid_cols. Each beat releases zero to four finished
// next-generation cells on the m_axis channel, one per beat, each with its
// row and column; tlast marks the last cell of the frame. Cells outside the
// grid are dead, so the grid does not wrap.
// A cell is accepted every cycle while each beat releases at most one result
// and m_axis_tready is high. A beat that releases several results holds the
// input while the single result register drains them, one result per cycle
// while m_axis_tready is high. An input beat passes the item stage and result
// register before its first result beat. After reset the block sweeps both
// 1024-entry row stores to zero, one entry per cycle; s_axis_tready stays low
// during the sweep. Configuration writes are taken at any time but belong only
// where the block is idle. When m_axis_tready is low the result holds, and
// the block keeps taking input until item stage and result register are full.
module life_generation_stencil
  import lgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,   // [0] cell_alive
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // [0] next_alive, [16:1] out_row, [26:17] out_col
  output logic                  m_axis_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [ROW_W-1:0]      grid_rows;
  logic [CFG_COLS_W-1:0] grid_cols;
  logic [ROW_W-1:0]      row_position;
  logic [COL_W-1:0]      col_position;
  logic [ROW_W-1:0]      rows_m1;
  logic [CFG_COLS_W-1:0] cols_m1_wide;
  logic [COL_W-1:0]      cols_m1;
  logic [ROW_W-1:0]      cur_row;
  logic [COL_W-1:0]      cur_col;
  logic                  accept;
  logic                  lb_busy;
  logic                  stage_busy;
  logic                  res_free;
  logic                  res_load;
  logic                  lb_up;
  logic                  lb_mid;
  lgs_item_t             item_in;
  lgs_wr_t               wr;
  lgs_res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= ROW_W'(1);
      grid_cols <= CFG_COLS_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows <= cfg_wdata[ROW_W-1:0];
        REG_GRID_COLS: grid_cols <= cfg_wdata[CFG_COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_m1 = (grid_rows == '0) ? '0 : grid_rows - 1'b1;
    if (grid_cols == '0) begin
      cols_m1_wide = '0;
    end else if (grid_cols > CFG_COLS_W'(MAX_COLS)) begin
      cols_m1_wide = CFG_COLS_W'(MAX_COLS - 1);
    end else begin
      cols_m1_wide = grid_cols - 1'b1;
    end
    cols_m1 = cols_m1_wide[COL_W-1:0];
    cur_row = (row_position > rows_m1) ? rows_m1 : row_position;
    cur_col = (col_position > cols_m1) ? cols_m1 : col_position;

    item_in.row      = cur_row;
    item_in.col      = cur_col;
    item_in.last_row = (cur_row == rows_m1);
    item_in.row_end  = (cur_col == cols_m1);
    item_in.alive    = s_axis_tdata[0];
  end

  assign s_axis_tready = !lb_busy && !stage_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      col_position <= '0;
    end else if (accept) begin
      if (item_in.row_end) begin
        col_position <= '0;
        row_position <= item_in.last_row ? '0 : cur_row + 1'b1;
      end else begin
        col_position <= cur_col + 1'b1;
        row_position <= cur_row;
      end
    end
  end

  lgs_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (cur_col),
    .wr      (wr),
    .busy    (lb_busy),
    .up      (lb_up),
    .mid     (lb_mid)
  );

  lgs_window u_window (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .item_in    (item_in),
    .up         (lb_up),
    .mid        (lb_mid),
    .res_free   (res_free),
    .busy_stage (stage_busy),
    .wr         (wr),
    .res_load   (res_load),
    .res        (res)
  );

  lgs_result_reg u_result_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res_in   (res),
    .tready   (m_axis_tready),
    .tvalid   (m_axis_tvalid),
    .tdata    (m_axis_tdata),
    .tlast    (m_axis_tlast),
    .res_free (res_free)
  );

endmodule

@@ rtl/core/lgs_checker.sv @@
// Port-level checks for the life generation stencil, bound to the top level.
// Depends on lgs_pkg and life_generation_stencil.
module lgs_checker
  import lgs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  logic frame_start;
  logic out_beat;

  assign out_beat = m_axis_tvalid && m_axis_tready;

  // Set at reset and after the last cell of a frame; the next frame opens on row 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start <= 1'b1;
    end else if (out_beat) begin
      frame_start <= m_axis_tlast;
    end
  end

  a_reset_no_result: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_reset_clearing: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready during row store clearing");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_frame_row0: assert property (@(posedge clk) disable iff (rst)
    out_beat && frame_start |-> m_axis_tdata[ROW_W:1] == '0)
    else $error("frame does not open on row 0");

endmodule

bind life_generation_stencil lgs_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
